>>> src/mcwsa_pkg.sv
package mcwsa_pkg;

	localparam int NUM_CHANNELS = 8;
	localparam int WINDOW       = 16;
	localparam int SAMPLE_BITS  = 12;

	localparam int CHANNEL_W = 4;
	localparam int VALUE_W   = 12;
	localparam int VALUE_MAX = 4095;
	localparam int AVG_SHIFT = 3;

	localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int PTR_W   = $clog2(WINDOW);
	localparam int DEPTH   = NUM_CHANNELS * WINDOW;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W   = SAMPLE_BITS + PTR_W;

	localparam logic CMD_STORE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EXEC  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

endpackage

>>> src/multichannel_window_sum_averager.sv
// Channel | Signals                            | Direction
// --------+------------------------------------+----------
// input   | in_valid, in_stall, cmd, channel,  | in / out
//         | sample                             |
// output  | out_valid, out_stall, value        | out / in
//
// A store word is accepted, reads the old ring entry and, for a present channel, does the
// write-back with the update of the channel's running sum by the shared adder.
// A read word is accepted, then the clamp and shift of the running sum are registered.
// Reset clears the running sums, write pointers and per-entry valid bits at once,
// so no clearing pass is needed.
// A stalled result waits in the output register; the next word is taken meanwhile,
// and a further read waits in ST_EXEC until the register is free.
module multichannel_window_sum_averager
	import mcwsa_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [CHANNEL_W-1:0]          channel,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [VALUE_W-1:0]            value
);

	state_t                         state_q;
	logic                           cmd_q;
	logic [CHANNEL_W-1:0]           ch_q;
	logic                           ch_ok_q;
	logic signed [SAMPLE_BITS-1:0]  sample_q;

	logic [PTR_W-1:0]               wptr_q [NUM_CHANNELS];
	logic signed [SUM_W-1:0]        sums_q [NUM_CHANNELS];

	logic [SAMPLE_BITS-1:0]         mem [DEPTH];
	logic [DEPTH-1:0]               vld_q;
	logic [SAMPLE_BITS-1:0]         rd_data_q;
	logic                           rd_vld_q;

	logic                           out_valid_q;
	logic [VALUE_W-1:0]             value_q;

	logic                           in_acc;
	logic [CH_W-1:0]                ch_idx;
	logic [PTR_W-1:0]               ptr;
	logic [PTR_W-1:0]               ptr_next;
	logic [ADDR_W-1:0]              addr;
	logic signed [SAMPLE_BITS-1:0]  old_sample;
	logic signed [SUM_W-1:0]        sum_cur;
	logic signed [SUM_W-1:0]        sum_next;
	logic [SUM_W-1:0]               shifted;
	logic [VALUE_W-1:0]             avg;
	logic                           out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		ch_idx     = ch_q[CH_W-1:0];
		ptr        = wptr_q[ch_idx];
		ptr_next   = (ptr == PTR_W'(WINDOW - 1)) ? '0 : ptr + 1'b1;
		addr       = ADDR_W'(ADDR_W'(ch_idx) * ADDR_W'(WINDOW) + ADDR_W'(ptr));
		old_sample = rd_vld_q ? $signed(rd_data_q) : '0;
		sum_cur    = sums_q[ch_idx];
		sum_next   = sum_cur + SUM_W'(sample_q) - SUM_W'(old_sample);
		shifted    = $unsigned(sum_cur) >> AVG_SHIFT;
		if (!ch_ok_q || sum_cur[SUM_W-1]) begin
			avg = '0;
		end else if (shifted > SUM_W'(VALUE_MAX)) begin
			avg = VALUE_W'(VALUE_MAX);
		end else begin
			avg = VALUE_W'(shifted);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			vld_q       <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				wptr_q[i] <= '0;
				sums_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_EXEC && cmd_q == CMD_READ && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd_q == CMD_STORE) begin
						state_q <= ch_ok_q ? ST_WRITE : ST_IDLE;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WRITE: begin
					vld_q[addr]    <= 1'b1;
					sums_q[ch_idx] <= sum_next;
					wptr_q[ch_idx] <= ptr_next;
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= cmd;
			ch_q     <= channel;
			ch_ok_q  <= ({1'b0, channel} < (CHANNEL_W + 1)'(NUM_CHANNELS));
			sample_q <= sample;
		end
		if (state_q == ST_EXEC && cmd_q == CMD_READ && out_free) begin
			value_q <= avg;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[addr];
		rd_vld_q  <= vld_q[addr];
		if (state_q == ST_WRITE) begin
			mem[addr] <= sample_q;
		end
	end

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register is not one-hot");

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC && cmd_q == CMD_READ))
		else $error("result word raised without a read in progress");

	a_write_returns: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |=> state_q == ST_IDLE)
		else $error("write-back did not return to idle");

	a_write_only_valid_channel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> ch_ok_q && cmd_q == CMD_STORE)
		else $error("write-back for an absent channel or a read word");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import mcwsa_pkg::*;

	class window_sum_tracker;
		logic signed [SAMPLE_BITS-1:0] ring [NUM_CHANNELS][WINDOW];
		logic [PTR_W-1:0] wr_ptr [NUM_CHANNELS];
		logic [VALUE_W-1:0] expected_values [$];
		int errors;
		int reads_checked;

		function new();
			foreach (ring[c, k]) ring[c][k] = '0;
			foreach (wr_ptr[c]) wr_ptr[c] = '0;
			errors = 0;
			reads_checked = 0;
		endfunction

		function int pending();
			return expected_values.size();
		endfunction

		function void note_word(logic c, logic [CHANNEL_W-1:0] ch,
				logic signed [SAMPLE_BITS-1:0] s);
			int total;
			int shifted;
			logic [VALUE_W-1:0] v;
			if (c == CMD_STORE) begin
				if (ch < NUM_CHANNELS) begin
					ring[ch][wr_ptr[ch]] = s;
					wr_ptr[ch] = (int'(wr_ptr[ch]) == WINDOW - 1) ? '0 : wr_ptr[ch] + 1'b1;
				end
			end else begin
				v = '0;
				if (ch < NUM_CHANNELS) begin
					total = 0;
					for (int k = 0; k < WINDOW; k++) total += int'(ring[ch][k]);
					if (total > 0) begin
						shifted = total >>> AVG_SHIFT;
						v = (shifted > VALUE_MAX) ? VALUE_W'(VALUE_MAX) : VALUE_W'(shifted);
					end
				end
				expected_values.push_back(v);
			end
		endfunction

		function void check_value(logic [VALUE_W-1:0] got);
			logic [VALUE_W-1:0] want;
			if (expected_values.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0d", $time, got);
			end else begin
				want = expected_values.pop_front();
				reads_checked++;
				if (got !== want) begin
					errors++;
					$display("%0t: value mismatch, expected %0d, actual %0d", $time, want, got);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = CMD_STORE;
	logic [CHANNEL_W-1:0] channel = '0;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [VALUE_W-1:0] value;

	window_sum_tracker tracker = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int words_sent = 0;
	int input_stall_cycles = 0;

	multichannel_window_sum_averager DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.channel(channel),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value(value)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Result side: checks each accepted word and chooses the next stall.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) tracker.check_value(value);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic send_word(input logic c, input logic [CHANNEL_W-1:0] ch,
			input logic signed [SAMPLE_BITS-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		channel <= ch;
		sample <= s;
		@(posedge clk);
		while (in_stall) begin
			input_stall_cycles++;
			@(posedge clk);
		end
		tracker.note_word(c, ch, s);
		words_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int mode);
		case (mode)
			0: return SAMPLE_BITS'($urandom_range(4095));
			1: return SAMPLE_BITS'($urandom_range(2047, 1024));
			2: return SAMPLE_BITS'(-int'($urandom_range(2048, 1024)));
			default: return $urandom_range(1) ? 12'sd2047 : -12'sd2048;
		endcase
	endfunction

	task automatic run_directed();
		send_word(CMD_READ, 4'd0, '0);
		send_word(CMD_READ, 4'd15, '0);
		send_word(CMD_STORE, 4'd9, 12'sd2047);
		send_word(CMD_READ, 4'd9, '0);
		for (int k = 0; k < WINDOW; k++) send_word(CMD_STORE, 4'd7, -12'sd2048);
		send_word(CMD_READ, 4'd7, '0);
		send_word(CMD_STORE, 4'd7, 12'sd2047);
		send_word(CMD_READ, 4'd7, '0);
	endtask

	// Mostly bursts of stores to one channel followed by reads, with some noise.
	task automatic run_random(int target);
		int done;
		int len;
		int mode;
		logic [CHANNEL_W-1:0] ch;
		done = 0;
		while (done < target) begin
			if ($urandom_range(9) == 0) begin
				ch = CHANNEL_W'($urandom_range(15));
				if ($urandom_range(1)) begin
					send_word(CMD_READ, ch, SAMPLE_BITS'($urandom_range(4095)));
					done++;
				end else begin
					send_word(CMD_STORE, ch, pick_sample(0));
					if (ch < NUM_CHANNELS) done++;
				end
			end else begin
				ch = ($urandom_range(15) == 0) ? CHANNEL_W'($urandom_range(15, 8))
					: CHANNEL_W'($urandom_range(7));
				mode = $urandom_range(3);
				len = $urandom_range(20, 1);
				for (int k = 0; k < len; k++) send_word(CMD_STORE, ch, pick_sample(mode));
				if (ch < NUM_CHANNELS) done += len;
				len = $urandom_range(2, 1);
				for (int k = 0; k < len; k++) send_word(CMD_READ, ch, '0);
				done += len;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 14;
		recv_stall_pct = 88;
		run_directed();
		run_random(480);
		drain_results();

		send_idle_pct = 88;
		recv_stall_pct = 14;
		run_random(500);
		drain_results();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b1;
		for (int k = 0; k < 40; k++) send_word(CMD_READ, 4'($urandom_range(7)), '0);
		run_random(460);
		drain_results();
		repeat (10) @(posedge clk);

		$display("Sent %0d words under three idle patterns; %0d filtered values checked.",
			words_sent, tracker.reads_checked);
		$display("The input was held off for %0d cycles, including one long output stall.",
			input_stall_cycles);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

>>> multichannel_window_sum_averager.f
src/mcwsa_pkg.sv
src/multichannel_window_sum_averager.sv
dv/tb.sv
